/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTD converter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTDCT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rtd converter assertion failed");
`define RTDCT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("rtd converter assertion failed");
`else
`define RTDCT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RTDCT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/rtdct_pkg.sv */
// Types and constants of the RTD code to temperature converter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rtdct_pkg;

	localparam int unsigned CODE_W     = 15;
	localparam int unsigned RES_W      = 24;
	localparam int unsigned TEMP_W     = 19;
	localparam int unsigned FB_W       = 8;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = 2;
	localparam int unsigned SQ_IN_W    = 58;
	localparam int unsigned SQ_OUT_W   = 29;
	localparam int unsigned SQ_REM_W   = 30;
	localparam int unsigned DV_N_W     = 48;
	localparam int unsigned DV_D_W     = 31;
	localparam int unsigned DV_Q_W     = 20;

	localparam logic [26:0] FOURB      = 27'd90234375;
	localparam logic [26:0] QUAD2      = 27'd100000000;
	localparam logic [22:0] LIN2       = 23'd5000000;
	localparam logic [18:0] A_E8       = 19'd390830;
	localparam logic [47:0] BASE_100   = 48'd15274808890000;
	localparam logic [47:0] BASE_1000  = 48'd152748088900000;
	localparam logic [17:0] R0U_100    = 18'd25600;
	localparam logic [17:0] R0U_1000   = 18'd256000;
	localparam logic [9:0]  R0_100     = 10'd100;
	localparam logic [9:0]  R0_1000    = 10'd1000;
	localparam logic [30:0] LDEN_100   = 31'd7816600;
	localparam logic [30:0] LDEN_1000  = 31'd78166000;
	localparam logic [30:0] LHALF_100  = 31'd3908300;
	localparam logic [30:0] LHALF_1000 = 31'd39083000;
	localparam logic [18:0] T_MAX      = 19'd262143;
	localparam logic [23:0] REF_RESET  = 24'd110080;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAULT = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		CFG_REF_RES     = 1'b0,
		CFG_SENSOR_KIND = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [23:0] ref_res;
		logic        kind;
	} cfg_t;

	typedef struct packed {
		logic [14:0] code;
		logic        fault;
		logic [7:0]  fbyte;
	} item_t;

	typedef struct packed {
		item_t       item;
		logic [23:0] res;
		logic        ge;
		logic        neg;
		logic [47:0] qnum;
		logic [41:0] lnum;
	} sq_tag_t;

	typedef struct packed {
		item_t       item;
		logic [23:0] res;
		logic        ge;
		logic        neg;
	} dv_tag_t;

	typedef struct packed {
		logic [14:0] raw_code;
		logic [23:0] resistance;
		logic [18:0] temperature;
		logic [7:0]  fault_code;
		status_t     status;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/rtd_code_to_temperature.sv */
// RTD code to temperature converter, PT100 or PT1000 element. Each item carries
// the converter's two result bytes and its fault byte; the block returns the code,
// the resistance in 1/256 ohm and the temperature in 1/64 degree C. One item is
// taken every cycle while the result side keeps up; each accepted item passes through
// the queue, four stages ahead of the 29-stage square root, one ahead of the 20-stage
// divider and the output register.
`default_nettype none
`include "assert_macros.svh"
module rtd_code_to_temperature (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // code_high_byte, code_low_byte, fault_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,  // raw_code, resistance_out, temperature_out,
	                                   // fault_code, zero fill
	output logic [1:0]       m_tuser   // result_status
);

	rtdct_pkg::cfg_t         cfg_q;
	logic                    q_valid;
	rtdct_pkg::item_t        q_item;
	logic                    q_pop;
	rtdct_pkg::result_t      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_res <= rtdct_pkg::REF_RESET;
			cfg_q.kind    <= 1'b0;
		end else if (cfg_we) begin
			unique case (rtdct_pkg::cfg_idx_t'(cfg_index))
				rtdct_pkg::CFG_REF_RES: begin
					cfg_q.ref_res <= cfg_data;
				end
				rtdct_pkg::CFG_SENSOR_KIND: begin
					cfg_q.kind <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	rtdct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	rtdct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {6'b0, res.fault_code, res.temperature, res.resistance, res.raw_code};
	assign m_tuser = res.status;

	`RTDCT_ASSERT_IMPLIES(a_fault_zero, clk, arst_n, m_tvalid && (m_tuser == rtdct_pkg::ST_FAULT), m_tdata[57:15] == '0)
	`RTDCT_ASSERT_IMPLIES(a_range_sat, clk, arst_n, m_tvalid && (m_tuser == rtdct_pkg::ST_RANGE), m_tdata[57:39] == rtdct_pkg::T_MAX)
	`RTDCT_ASSERT_NEVER(a_ok_no_fault, clk, arst_n, m_tvalid && (m_tuser != rtdct_pkg::ST_FAULT) && (m_tdata[65:58] != '0))

endmodule
`default_nettype wire

/* hw/rtl/rtdct_front.sv */
// Front end: accepts items, forms the code and fault flag, and queues them.
// Depends on rtdct_pkg.
`default_nettype none
module rtdct_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,
	output logic                   q_valid,
	output rtdct_pkg::item_t       q_item,
	input  wire logic              q_pop
);

	rtdct_pkg::item_t                      mem_q [rtdct_pkg::FIFO_DEPTH];
	logic [rtdct_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [rtdct_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [rtdct_pkg::FIFO_PTR_W:0]        count_q;
	rtdct_pkg::item_t                      in_item;
	logic                                  push;
	logic                                  pop;

	always_comb begin
		in_item.code  = {s_tdata[7:0], s_tdata[15:9]};
		in_item.fault = s_tdata[8];
		in_item.fbyte = s_tdata[23:16];
	end

	assign s_tready = count_q != (rtdct_pkg::FIFO_PTR_W+1)'(rtdct_pkg::FIFO_DEPTH);
	assign q_valid  = count_q != '0;
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/rtdct_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on rtdct_pkg; carries a tag alongside the operand.
`default_nettype none
module rtdct_isqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire logic [rtdct_pkg::SQ_IN_W-1:0]   in_val,
	input  wire rtdct_pkg::sq_tag_t              in_tag,
	output logic                                 out_valid,
	output logic [rtdct_pkg::SQ_OUT_W-1:0]       out_root,
	output rtdct_pkg::sq_tag_t                   out_tag
);

	localparam int unsigned NS = rtdct_pkg::SQ_OUT_W;

	logic [NS:0]                               vld;
	logic [NS:0][rtdct_pkg::SQ_IN_W-1:0]       val;
	logic [NS:0][rtdct_pkg::SQ_REM_W-1:0]      rem;
	logic [NS:0][rtdct_pkg::SQ_OUT_W-1:0]      root;
	rtdct_pkg::sq_tag_t                        tag [NS+1];

	assign vld[0]  = in_valid;
	assign val[0]  = in_val;
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign tag[0]  = in_tag;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [rtdct_pkg::SQ_REM_W+1:0] rem_x;
		logic [rtdct_pkg::SQ_REM_W+1:0] trial;
		logic                           take;

		always_comb begin
			rem_x = {rem[i], val[i][rtdct_pkg::SQ_IN_W-1 -: 2]};
			trial = {1'b0, root[i], 2'b01};
			take  = rem_x >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val[i+1]  <= {val[i][rtdct_pkg::SQ_IN_W-3:0], 2'b00};
				rem[i+1]  <= take ? rtdct_pkg::SQ_REM_W'(rem_x - trial)
				                  : rem_x[rtdct_pkg::SQ_REM_W-1:0];
				root[i+1] <= {root[i][rtdct_pkg::SQ_OUT_W-2:0], take};
				tag[i+1]  <= tag[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (en) begin
				vld[i+1] <= vld[i];
			end
		end
	end

	assign out_valid = vld[NS];
	assign out_root  = root[NS];
	assign out_tag   = tag[NS];

endmodule
`default_nettype wire

/* hw/rtl/rtdct_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rtdct_pkg; carries a tag alongside the operands.
`default_nettype none
module rtdct_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire logic [rtdct_pkg::DV_N_W-1:0]    in_num,
	input  wire logic [rtdct_pkg::DV_D_W-1:0]    in_den,
	input  wire rtdct_pkg::dv_tag_t              in_tag,
	output logic                                 out_valid,
	output logic [rtdct_pkg::DV_Q_W-1:0]         out_quo,
	output rtdct_pkg::dv_tag_t                   out_tag
);

	localparam int unsigned NS = rtdct_pkg::DV_Q_W;
	localparam int unsigned XW = rtdct_pkg::DV_D_W + rtdct_pkg::DV_Q_W - 1;

	logic [NS:0]                               vld;
	logic [NS:0][rtdct_pkg::DV_N_W-1:0]        rem;
	logic [NS:0][rtdct_pkg::DV_D_W-1:0]        den;
	logic [NS:0][rtdct_pkg::DV_Q_W-1:0]        quo;
	rtdct_pkg::dv_tag_t                        tag [NS+1];

	assign vld[0] = in_valid;
	assign rem[0] = in_num;
	assign den[0] = in_den;
	assign quo[0] = '0;
	assign tag[0] = in_tag;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam int unsigned K = NS - 1 - i;
		logic [XW-1:0] rem_x;
		logic [XW-1:0] den_x;
		logic          take;

		always_comb begin
			rem_x = XW'(rem[i]);
			den_x = XW'(den[i]) << K;
			take  = rem_x >= den_x;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[i+1] <= take ? rtdct_pkg::DV_N_W'(rem_x - den_x) : rem[i];
				den[i+1] <= den[i];
				quo[i+1] <= {quo[i][rtdct_pkg::DV_Q_W-2:0], take};
				tag[i+1] <= tag[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (en) begin
				vld[i+1] <= vld[i];
			end
		end
	end

	assign out_valid = vld[NS];
	assign out_quo   = quo[NS];
	assign out_tag   = tag[NS];

endmodule
`default_nettype wire

/* hw/rtl/rtdct_back.sv */
// Back end: resistance, discriminant, square root, division and result register.
// Depends on rtdct_pkg, rtdct_isqrt and rtdct_div.
`default_nettype none
module rtdct_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtdct_pkg::cfg_t   cfg,
	input  wire logic              q_valid,
	input  wire rtdct_pkg::item_t  q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rtdct_pkg::result_t     out_res
);

	logic                          adv;
	logic [9:0]                    r0;
	logic [17:0]                   r0u;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	rtdct_pkg::item_t              item_s1, item_s2, item_s3, item_s4;
	logic [23:0]                   res_s1, res_s2, res_s3, res_s4;
	logic [38:0]                   prod;

	logic                          ge_c;
	logic [23:0]                   d_c;
	logic [17:0]                   e_c;
	logic                          ge_s2, ge_s3, ge_s4;
	logic [50:0]                   sub_s2;
	logic [50:0]                   qnum_s2;
	logic [47:0]                   qnum_s3, qnum_s4;
	logic [41:0]                   lnum_s2, lnum_s3, lnum_s4;
	logic [47:0]                   base;
	logic                          neg_s3, neg_s4;
	logic [47:0]                   m_s3;
	logic [57:0]                   mr_s4;

	rtdct_pkg::sq_tag_t            sq_in_tag, sq_out_tag;
	logic                          sq_out_valid;
	logic [28:0]                   sq_root;
	logic [29:0]                   den_c;

	logic [47:0]                   num_s5;
	logic [30:0]                   dsr_s5;
	rtdct_pkg::dv_tag_t            tag_s5;
	logic                          dv_out_valid;
	logic [19:0]                   dv_quo;
	rtdct_pkg::dv_tag_t            dv_out_tag;
	rtdct_pkg::result_t            res_c;
	rtdct_pkg::result_t            res_s6;

	assign adv   = !vld_s6 || out_ready;
	assign q_pop = adv;
	assign r0    = cfg.kind ? rtdct_pkg::R0_1000 : rtdct_pkg::R0_100;
	assign r0u   = cfg.kind ? rtdct_pkg::R0U_1000 : rtdct_pkg::R0U_100;
	assign base  = cfg.kind ? rtdct_pkg::BASE_1000 : rtdct_pkg::BASE_100;
	assign prod  = {24'b0, q_item.code} * {15'b0, cfg.ref_res};

	always_comb begin
		ge_c = res_s1 >= {6'b0, r0u};
		d_c  = res_s1 - {6'b0, r0u};
		e_c  = r0u - res_s1[17:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;
			res_s1  <= prod[38:15];

			item_s2 <= item_s1;
			res_s2  <= res_s1;
			ge_s2   <= ge_c;
			sub_s2  <= {24'b0, rtdct_pkg::FOURB} * {27'b0, d_c};
			qnum_s2 <= {24'b0, rtdct_pkg::QUAD2} * {27'b0, d_c};
			lnum_s2 <= {19'b0, rtdct_pkg::LIN2} * {24'b0, e_c}
			         + {11'b0, (cfg.kind ? rtdct_pkg::LHALF_1000 : rtdct_pkg::LHALF_100)};

			item_s3 <= item_s2;
			res_s3  <= res_s2;
			ge_s3   <= ge_s2;
			neg_s3  <= sub_s2 > {3'b0, base};
			m_s3    <= base - sub_s2[47:0];
			qnum_s3 <= qnum_s2[47:0];
			lnum_s3 <= lnum_s2;

			item_s4 <= item_s3;
			res_s4  <= res_s3;
			ge_s4   <= ge_s3;
			neg_s4  <= neg_s3;
			mr_s4   <= {10'b0, m_s3} * {48'b0, r0};
			qnum_s4 <= qnum_s3;
			lnum_s4 <= lnum_s3;
		end
	end

	always_comb begin
		sq_in_tag.item = item_s4;
		sq_in_tag.res  = res_s4;
		sq_in_tag.ge   = ge_s4;
		sq_in_tag.neg  = neg_s4;
		sq_in_tag.qnum = qnum_s4;
		sq_in_tag.lnum = lnum_s4;
	end

	rtdct_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.in_val    (mr_s4),
		.in_tag    (sq_in_tag),
		.out_valid (sq_out_valid),
		.out_root  (sq_root),
		.out_tag   (sq_out_tag)
	);

	assign den_c = {11'b0, rtdct_pkg::A_E8} * {20'b0, r0} + {1'b0, sq_root};

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5.item <= sq_out_tag.item;
			tag_s5.res  <= sq_out_tag.res;
			tag_s5.ge   <= sq_out_tag.ge;
			tag_s5.neg  <= sq_out_tag.neg;
			if (sq_out_tag.ge) begin
				num_s5 <= sq_out_tag.qnum + {18'b0, den_c};
				dsr_s5 <= {den_c, 1'b0};
			end else begin
				num_s5 <= {6'b0, sq_out_tag.lnum};
				dsr_s5 <= cfg.kind ? rtdct_pkg::LDEN_1000 : rtdct_pkg::LDEN_100;
			end
		end
	end

	rtdct_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.in_num    (num_s5),
		.in_den    (dsr_s5),
		.in_tag    (tag_s5),
		.out_valid (dv_out_valid),
		.out_quo   (dv_quo),
		.out_tag   (dv_out_tag)
	);

	always_comb begin
		res_c.raw_code   = dv_out_tag.item.code;
		res_c.resistance = dv_out_tag.res;
		res_c.fault_code = '0;
		res_c.status     = rtdct_pkg::ST_OK;
		if (dv_out_tag.item.fault) begin
			res_c.resistance  = '0;
			res_c.temperature = '0;
			res_c.fault_code  = dv_out_tag.item.fbyte;
			res_c.status      = rtdct_pkg::ST_FAULT;
		end else if (dv_out_tag.ge && dv_out_tag.neg) begin
			res_c.temperature = rtdct_pkg::T_MAX;
			res_c.status      = rtdct_pkg::ST_RANGE;
		end else if (dv_out_tag.ge) begin
			res_c.temperature = dv_quo[18:0];
		end else begin
			res_c.temperature = 19'(~dv_quo[18:0] + 19'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_out_valid;
			vld_s6 <= dv_out_valid;
		end
	end

	assign out_valid = vld_s6;
	assign out_res   = res_s6;

endmodule
`default_nettype wire

/* bench/rtd_code_to_temperature_tb.sv */
// Self-checking testbench for the RTD code to temperature converter.
// It drives random and directed items, predicts each result and checks it.
// Depends on rtdct_pkg and rtd_code_to_temperature.
`timescale 1ns / 100ps
`default_nettype none
module rtd_code_to_temperature_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = rtdct_pkg::CFG_REF_RES;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [23:0]          ref_res_model = rtdct_pkg::REF_RESET;
	logic                 kind_model = 1'b0;
	logic [23:0]          item_queue[$];
	rtdct_pkg::result_t   expected_results[$];
	int                   send_idle = 0;
	int                   recv_idle = 0;
	int                   mismatches = 0;

	rtd_code_to_temperature i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic rtdct_pkg::result_t predict_reading(logic [23:0] word);
		longint unsigned code, res, r0, r0u, d, base, sub, s, den, num, e, mag, t;
		rtdct_pkg::result_t r;
		code = {word[7:0], word[15:9]};
		r = '0;
		r.raw_code = code[14:0];
		if (word[8]) begin
			r.fault_code = word[23:16];
			r.status = rtdct_pkg::ST_FAULT;
			return r;
		end
		res = (code * ref_res_model) >> 15;
		r0 = kind_model ? 1000 : 100;
		r0u = r0 * 256;
		r.status = rtdct_pkg::ST_OK;
		if (res >= r0u) begin
			d = res - r0u;
			base = 64'd390830 * 64'd390830 * r0;
			sub = 64'd90234375 * d;
			if (sub > base) begin
				t = rtdct_pkg::T_MAX;
				r.status = rtdct_pkg::ST_RANGE;
			end else begin
				s = floor_sqrt((base - sub) * r0);
				den = 64'd390830 * r0 + s;
				num = 64'd50000000 * d;
				t = (2 * num + den) / (2 * den);
			end
		end else begin
			e = r0u - res;
			den = 64'd39083 * r0;
			mag = (2 * 64'd2500000 * e + den) / (2 * den);
			t = 64'd0 - mag;
		end
		r.resistance = res[23:0];
		r.temperature = t[18:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= item_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(0, 99) >= recv_idle;
	end

	always @(posedge clk) begin
		rtdct_pkg::result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_reading(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item %h / %h", m_tdata, m_tuser);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[14:0] !== want.raw_code || m_tdata[38:15] !== want.resistance
							|| m_tdata[57:39] !== want.temperature
							|| m_tdata[65:58] !== want.fault_code
							|| m_tdata[71:66] !== 6'd0 || m_tuser !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected code %h res %h temp %h fault %h st %0d,"
								, want.raw_code, want.resistance, want.temperature,
								want.fault_code, want.status,
								" got tdata %h tuser %0d", m_tdata, m_tuser);
					end
				end
			end
		end
	end

	task automatic write_register(rtdct_pkg::cfg_idx_t idx, logic [23:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == rtdct_pkg::CFG_REF_RES)
			ref_res_model = value;
		else
			kind_model = value[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (item_queue.size() != 0)
			@(posedge clk);
		@(posedge clk);
		while (s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		logic [7:0] lo;
		repeat (count) begin
			lo = $urandom_range(0, 255);
			lo[0] = ($urandom_range(0, 7) == 0);
			item_queue.push_back({8'($urandom_range(0, 255)), lo, 8'($urandom_range(0, 255))});
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_register(rtdct_pkg::CFG_REF_RES, rtdct_pkg::REF_RESET);
		write_register(rtdct_pkg::CFG_SENSOR_KIND, 1'b0);
		send_idle = 29;
		recv_idle = 84;
		item_queue.push_back(24'h000000);
		item_queue.push_back(24'hFFFEFF);
		item_queue.push_back(24'hFFFFFF);
		item_queue.push_back(24'h000100);
		item_queue.push_back(24'hA5FFFF);
		item_queue.push_back(24'h00FE00);
		item_queue.push_back(24'hFFFE3B);
		item_queue.push_back(24'h805ED3);
		item_queue.push_back(24'h5A0077);
		item_queue.push_back(24'h550040);
		item_queue.push_back(24'h2AAA3B);
		item_queue.push_back(24'h55AA20);
		queue_random(150);
		drain();
		queue_random(150);
		drain();
		write_register(rtdct_pkg::CFG_REF_RES, 24'd1024000);
		write_register(rtdct_pkg::CFG_SENSOR_KIND, 1'b1);
		send_idle = 84;
		recv_idle = 29;
		item_queue.push_back(24'h00FF00);
		item_queue.push_back(24'hFE0000);
		queue_random(300);
		drain();
		write_register(rtdct_pkg::CFG_REF_RES, 24'hFFFFFF);
		write_register(rtdct_pkg::CFG_SENSOR_KIND, 1'b0);
		send_idle = 0;
		recv_idle = 0;
		item_queue.push_back(24'h00FEFF);
		item_queue.push_back(24'h020018);
		queue_random(250);
		drain();
		write_register(rtdct_pkg::CFG_REF_RES, 24'd0);
		write_register(rtdct_pkg::CFG_SENSOR_KIND, 1'b1);
		queue_random(100);
		drain();
		write_register(rtdct_pkg::CFG_REF_RES, 24'd4096000);
		queue_random(300);
		drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("rtd_code_to_temperature test passed");
		else
			$display("rtd_code_to_temperature test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("rtd_code_to_temperature test failed");
		$finish;
	end
endmodule
`default_nettype wire
